// ----- rtl/rgadr_pkg.sv -----
// ----------------------------------------------------------------------------
// rgadr_pkg: shared types and constants of the reorg gather address block
// Holds the request and result payload types, the register indexes and the
// legal upper bounds of the configuration registers.
// ----------------------------------------------------------------------------
package rgadr_pkg;

  // Upper bounds of the configuration registers.
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MAX_CHANNELS = 4096;
  localparam int MAX_STRIDE   = 8;

  // Register indexes on the write port.
  localparam logic [1:0] REG_SRC_WIDTH     = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_SRC_CHANNELS  = 2'd2;
  localparam logic [1:0] REG_STRIDE_FACTOR = 2'd3;

  // One destination coordinate.
  typedef struct packed {
    logic [9:0]  dest_row;
    logic [9:0]  dest_col;
    logic [17:0] dest_channel;
  } request_t;

  // One gather address.
  typedef struct packed {
    logic [31:0] source_index;
    logic        out_of_range;
  } result_t;

endpackage

// ----- rtl/rgadr_div.sv -----
// ----------------------------------------------------------------------------
// rgadr_div: pipelined unsigned divider
// Restoring division, one quotient bit per register stage, so NW stages in
// all. A sideband word travels alongside each operand pair.
// ----------------------------------------------------------------------------
module rgadr_div #(
  parameter int NW = 32, // dividend and quotient width, at least 2
  parameter int DW = 11, // divisor and remainder width
  parameter int PW = 1   // sideband width
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [PW-1:0] side_in,
  output logic          valid_out,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder,
  output logic [PW-1:0] side_out
);

  logic          vld  [NW];
  logic [NW-1:0] quo  [NW];
  logic [DW-1:0] rem  [NW];
  logic [DW-1:0] dvs  [NW];
  logic [PW-1:0] side [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [PW-1:0] s_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    // The first stage starts from the ports with a zero partial remainder.
    if (i == 0) begin : g_first
      assign v_in = valid_in;
      assign q_in = dividend;
      assign r_in = '0;
      assign d_in = divisor;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign q_in = quo[i-1];
      assign r_in = rem[i-1];
      assign d_in = dvs[i-1];
      assign s_in = side[i-1];
    end

    // Bring down the next dividend bit and try one subtraction.
    assign trial = {r_in, q_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dvs[i]  <= d_in;
      side[i] <= s_in;
      if (trial >= {1'b0, d_in}) begin
        rem[i] <= diff[DW-1:0];
        quo[i] <= {q_in[NW-2:0], 1'b1};
      end else begin
        rem[i] <= trial[DW-1:0];
        quo[i] <= {q_in[NW-2:0], 1'b0};
      end
    end
  end

  assign valid_out = vld[NW-1];
  assign quotient  = quo[NW-1];
  assign remainder = rem[NW-1];
  assign side_out  = side[NW-1];

  // A finished division leaves a remainder below a non-zero divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (vld[NW-1] && dvs[NW-1] != '0) |-> (rem[NW-1] < dvs[NW-1]))
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/reorg_gather_address.sv -----
// ----------------------------------------------------------------------------
// reorg_gather_address: gather address generator for a space-to-depth reorg
// Turns one destination coordinate into the linear source index to read.
// ----------------------------------------------------------------------------
// The block takes one request in every clock cycle and never stalls: busy is
// always low, so a request transfers at each edge where start is high. Each
// result appears on the result port for one cycle with done high, in request
// order. The pipeline is mostly a chain of bit-per-stage dividers (by
// stride, by source width and height, by the channel split). The receiver
// must take every result as it comes. Registers are written through wr_en,
// wr_index and wr_data; the user must write them only while no request is
// in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module reorg_gather_address (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rgadr_pkg::request_t request,
  output logic                done,
  output rgadr_pkg::result_t  result,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [12:0]         wr_data
);

  // Divider lengths and the resulting latency.
  localparam int NW_FRONT = 13;
  localparam int NW_IDX   = 32;
  localparam int NW_CH    = 13;
  localparam int NW_LI    = 42;
  localparam int LATENCY  = 8 + NW_FRONT + 2 * NW_IDX + 2 * NW_CH + 2 * NW_LI;

  // Configuration registers.
  logic [10:0] src_width;
  logic [10:0] src_height;
  logic [12:0] src_channels;
  logic [3:0]  stride_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= 11'd1;
      src_height    <= 11'd1;
      src_channels  <= 13'd4;
      stride_factor <= 4'd2;
    end else if (wr_en) begin
      unique case (wr_index)
        rgadr_pkg::REG_SRC_WIDTH:     src_width     <= wr_data[10:0];
        rgadr_pkg::REG_SRC_HEIGHT:    src_height    <= wr_data[10:0];
        rgadr_pkg::REG_SRC_CHANNELS:  src_channels  <= wr_data;
        rgadr_pkg::REG_STRIDE_FACTOR: stride_factor <= wr_data[3:0];
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Registers in their legal ranges.
  logic cfg_ok;
  assign cfg_ok = (src_width != '0) && (src_width <= 11'(rgadr_pkg::MAX_WIDTH)) &&
                  (src_height != '0) && (src_height <= 11'(rgadr_pkg::MAX_HEIGHT)) &&
                  (src_channels != '0) &&
                  (src_channels <= 13'(rgadr_pkg::MAX_CHANNELS)) &&
                  (stride_factor != '0) &&
                  (stride_factor <= 4'(rgadr_pkg::MAX_STRIDE));

  // Stage A: capture the request.
  logic                va;
  rgadr_pkg::request_t req_a;
  logic                ok_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= accept;
    end
  end

  always_ff @(posedge clk) begin
    req_a <= request;
    ok_a  <= cfg_ok;
  end

  // Front dividers: destination width, height and the channel group count.
  logic [7:0]  stride_sq;
  logic        vf;
  logic [12:0] dw_f;
  logic [12:0] dh_f;
  logic [12:0] bigc_f;
  logic [19:0] rc_f;
  logic [17:0] chn_f;
  logic        ok_f;

  assign stride_sq = 8'(stride_factor * stride_factor);

  rgadr_div #(.NW(NW_FRONT), .DW(8), .PW(20)) u_div_dw (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (va),
    .dividend  ({2'b00, src_width}),
    .divisor   ({4'b0000, stride_factor}),
    .side_in   ({req_a.dest_row, req_a.dest_col}),
    .valid_out (vf),
    .quotient  (dw_f),
    .remainder (),
    .side_out  (rc_f)
  );

  rgadr_div #(.NW(NW_FRONT), .DW(8), .PW(18)) u_div_dh (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (va),
    .dividend  ({2'b00, src_height}),
    .divisor   ({4'b0000, stride_factor}),
    .side_in   (req_a.dest_channel),
    .valid_out (),
    .quotient  (dh_f),
    .remainder (),
    .side_out  (chn_f)
  );

  rgadr_div #(.NW(NW_FRONT), .DW(8), .PW(1)) u_div_bigc (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (va),
    .dividend  (src_channels),
    .divisor   (stride_sq),
    .side_in   (ok_a),
    .valid_out (),
    .quotient  (bigc_f),
    .remainder (),
    .side_out  (ok_f)
  );

  // Stage B: range checks and the first partial products.
  logic [9:0]  row_f;
  logic [9:0]  col_f;
  logic [20:0] dest_c;
  logic        bad_next_b;
  logic        vb;
  logic        bad_b;
  logic [28:0] p1_b;
  logic [20:0] p2_b;
  logic [9:0]  col_b;
  logic [10:0] dw_b;
  logic [12:0] bigc_b;

  assign row_f      = rc_f[19:10];
  assign col_f      = rc_f[9:0];
  assign dest_c     = 21'(src_channels * stride_sq);
  assign bad_next_b = !ok_f || (bigc_f == '0) || ({3'b000, row_f} >= dh_f) ||
                      ({3'b000, col_f} >= dw_f) || ({3'b000, chn_f} >= dest_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= vf;
    end
  end

  always_ff @(posedge clk) begin
    bad_b  <= bad_next_b;
    p1_b   <= 29'(chn_f * dh_f[10:0]);
    p2_b   <= 21'(row_f * dw_f[10:0]);
    col_b  <= col_f;
    dw_b   <= dw_f[10:0];
    bigc_b <= bigc_f;
  end

  // Stage C: channel-major destination index.
  logic        vc;
  logic [31:0] idx_c;
  logic [12:0] bigc_c;
  logic        bad_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    idx_c  <= 32'(p1_b * dw_b) + 32'(p2_b) + 32'(col_b);
    bigc_c <= bigc_b;
    bad_c  <= bad_b;
  end

  // Split the destination index over source width, height and channel.
  logic        v1;
  logic [31:0] t_1;
  logic [10:0] sx_1;
  logic [13:0] side_1;
  logic        v2;
  logic [31:0] ch_2;
  logic [10:0] sy_2;
  logic [24:0] side_2;

  rgadr_div #(.NW(NW_IDX), .DW(11), .PW(14)) u_div_sx (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (vc),
    .dividend  (idx_c),
    .divisor   (src_width),
    .side_in   ({bigc_c, bad_c}),
    .valid_out (v1),
    .quotient  (t_1),
    .remainder (sx_1),
    .side_out  (side_1)
  );

  rgadr_div #(.NW(NW_IDX), .DW(11), .PW(25)) u_div_sy (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v1),
    .dividend  (t_1),
    .divisor   (src_height),
    .side_in   ({sx_1, side_1}),
    .valid_out (v2),
    .quotient  (ch_2),
    .remainder (sy_2),
    .side_out  (side_2)
  );

  // Channel split: group offset and channel within the group.
  logic        v3;
  logic [12:0] off_3;
  logic [12:0] bc_3;
  logic [22:0] side_3;
  logic        v4;
  logic [12:0] offq_4;
  logic [3:0]  offr_4;
  logic [35:0] side_4;

  rgadr_div #(.NW(NW_CH), .DW(13), .PW(23)) u_div_bc (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v2),
    .dividend  (ch_2[12:0]),
    .divisor   (side_2[13:1]),
    .side_in   ({side_2[24:14], sy_2, side_2[0]}),
    .valid_out (v3),
    .quotient  (off_3),
    .remainder (bc_3),
    .side_out  (side_3)
  );

  rgadr_div #(.NW(NW_CH), .DW(4), .PW(36)) u_div_off (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v3),
    .dividend  (off_3),
    .divisor   (stride_factor),
    .side_in   ({side_3[22:1], bc_3, side_3[0]}),
    .valid_out (v4),
    .quotient  (offq_4),
    .remainder (offr_4),
    .side_out  (side_4)
  );

  // Stage D: coordinates in the enlarged plane.
  logic [10:0] sx_4;
  logic [10:0] sy_4;
  logic [12:0] bc_4;
  logic        vd;
  logic [15:0] bx_d;
  logic [15:0] by_d;
  logic [23:0] hb_d;
  logic        bad_d;

  assign sx_4 = side_4[35:25];
  assign sy_4 = side_4[24:14];
  assign bc_4 = side_4[13:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= v4;
    end
  end

  always_ff @(posedge clk) begin
    bx_d  <= 16'(sx_4 * stride_factor) + 16'(offr_4);
    by_d  <= 16'(sy_4 * stride_factor) + 16'(offq_4);
    hb_d  <= 24'(src_height * bc_4);
    bad_d <= side_4[0];
  end

  // Stage E: row of the enlarged plane and its width.
  logic        ve;
  logic [15:0] bx_e;
  logic [27:0] row_e;
  logic [14:0] bw_e;
  logic        bad_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    bx_e  <= bx_d;
    row_e <= 28'(hb_d * stride_factor) + 28'(by_d);
    bw_e  <= 15'(src_width * stride_factor);
    bad_e <= bad_d;
  end

  // Stage F: linear index in the enlarged plane.
  logic        vf2;
  logic [41:0] li_f;
  logic        bad_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf2 <= 1'b0;
    end else begin
      vf2 <= ve;
    end
  end

  always_ff @(posedge clk) begin
    li_f  <= 42'(bw_e * row_e) + 42'(bx_e);
    bad_f <= bad_e;
  end

  // Split the enlarged index over source width and height.
  logic        v5;
  logic [41:0] t_5;
  logic [10:0] px_5;
  logic        bad_5;
  logic        v6;
  logic [41:0] pc_6;
  logic [10:0] py_6;
  logic [11:0] side_6;

  rgadr_div #(.NW(NW_LI), .DW(11), .PW(1)) u_div_px (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (vf2),
    .dividend  (li_f),
    .divisor   (src_width),
    .side_in   (bad_f),
    .valid_out (v5),
    .quotient  (t_5),
    .remainder (px_5),
    .side_out  (bad_5)
  );

  rgadr_div #(.NW(NW_LI), .DW(11), .PW(12)) u_div_py (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v5),
    .dividend  (t_5),
    .divisor   (src_height),
    .side_in   ({px_5, bad_5}),
    .valid_out (v6),
    .quotient  (pc_6),
    .remainder (py_6),
    .side_out  (side_6)
  );

  // Stage G: partial products of the row-major source index.
  logic        vg;
  logic [21:0] a_g;
  logic [23:0] b_g;
  logic [31:0] pc_g;
  logic        bad_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else begin
      vg <= v6;
    end
  end

  always_ff @(posedge clk) begin
    a_g   <= 22'(py_6 * src_width);
    b_g   <= 24'(side_6[11:1] * src_channels);
    pc_g  <= pc_6[31:0];
    bad_g <= side_6[0];
  end

  // Stage H: output register; a rejected request reads as index zero.
  logic [31:0] sum_h;

  assign sum_h = 32'(a_g * src_channels) + 32'(b_g) + pc_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vg;
    end
  end

  always_ff @(posedge clk) begin
    result.source_index <= bad_g ? 32'd0 : sum_h;
    result.out_of_range <= bad_g;
  end

  // Every transfer in gives a result at the pipeline latency.
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing at the expected latency");

  // A rejected request never carries an address.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.out_of_range) |-> (result.source_index == 32'd0))
    else $error("rejected request with non-zero index");

  // Bad configuration at the range check always rejects the request.
  a_bad_cfg: assert property (@(posedge clk) disable iff (rst)
    (vf && !ok_f) |=> (vb && bad_b))
    else $error("bad configuration not flagged");

endmodule
